### src/lrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_pkg: shared types, codes and tables for the link route selector
// Event kinds, route modes, per-link record layout, reset and energy tables,
// the divide-by-ten helper and the score adjustment by mode.
// ----------------------------------------------------------------------------
package lrs_pkg;

  localparam int DefaultNumLinks = 4;

  // field widths
  localparam int KindW     = 3;
  localparam int LinkIdW   = 2;
  localparam int LatW      = 16;
  localparam int DepthW    = 16;
  localparam int TimeW     = 32;
  localparam int ModeW     = 3;
  localparam int MarginW   = 16;
  localparam int DeliveryW = 10;
  localparam int StreakW   = 8;
  localparam int ScoreW    = 18;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 32;
  localparam int InDataW   = 72;
  localparam int OutDataW  = 24;

  // event kinds
  localparam logic [KindW-1:0] KindSetUp   = 3'd0;
  localparam logic [KindW-1:0] KindSetLive = 3'd1;
  localparam logic [KindW-1:0] KindSuccess = 3'd2;
  localparam logic [KindW-1:0] KindFailure = 3'd3;
  localparam logic [KindW-1:0] KindQueue   = 3'd4;
  localparam logic [KindW-1:0] KindChoose  = 3'd5;

  // route modes
  localparam logic [ModeW-1:0] ModeBalanced  = 3'd0;
  localparam logic [ModeW-1:0] ModeOnlyFirst = 3'd1;
  localparam logic [ModeW-1:0] ModeOnlyLast  = 3'd4;
  localparam logic [ModeW-1:0] ModeRange     = 3'd5;
  localparam logic [ModeW-1:0] ModePowerSave = 3'd6;
  localparam logic [ModeW-1:0] ModeRedundant = 3'd7;

  // config register indexes
  localparam logic [CfgIdxW-1:0] CfgRouteMode  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxAge     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSticky     = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgHysteresis = 2'd3;

  // config reset values
  localparam logic [ModeW-1:0]   RstRouteMode  = ModeBalanced;
  localparam logic [TimeW-1:0]   RstMaxAge     = 32'd30000;
  localparam logic [TimeW-1:0]   RstSticky     = 32'd5000;
  localparam logic [MarginW-1:0] RstHysteresis = 16'd200;

  // score terms
  localparam logic [LatW-1:0]      LatCap       = 16'd2500;
  localparam logic [DepthW-1:0]    QueueCapFrom = 16'd14;   // 90*14 is past the cap
  localparam logic [10:0]          QueueCap     = 11'd1200;
  localparam logic [6:0]           QueueWeight  = 7'd90;
  localparam logic [7:0]           StreakWeight = 8'd250;
  localparam logic [StreakW-1:0]   StreakMax    = 8'd255;
  localparam logic [StreakW-1:0]   StreakDrop   = 8'd3;
  localparam logic [DeliveryW-1:0] LiveFloor    = 10'd300;
  localparam logic [19:0]          SuccessAdd   = 20'd3000;
  localparam logic [ScoreW-1:0]    BonusRange3  = 18'sd420;
  localparam logic [ScoreW-1:0]    BonusRange2  = 18'sd320;
  localparam logic [ScoreW-1:0]    BonusRange0  = 18'sd260;
  localparam logic [ScoreW-1:0]    BonusLink1   = 18'sd250;

  // x/10 as x*ceil(2^23/10) >> 23, exact for x below 2^22
  localparam logic [23:0] DivTenMul   = 24'd838861;
  localparam int          DivTenShift = 23;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [LinkIdW-1:0] link_id;
    logic               flag;
    logic [LatW-1:0]    latency;
    logic [DepthW-1:0]  depth;
    logic [TimeW-1:0]   now;
  } event_t;

  typedef struct packed {
    logic [DeliveryW-1:0] delivery;
    logic [LatW-1:0]      latency;
    logic [DepthW-1:0]    queue;
    logic [StreakW-1:0]   streak;
    logic                 up;
    logic                 live;
    logic [TimeW-1:0]     utime;
  } link_rec_t;

  typedef struct packed {
    logic [LinkIdW-1:0]       chosen;
    logic signed [ScoreW-1:0] score;
    logic                     none;
  } result_t;

  function automatic logic [DeliveryW-1:0] init_delivery(input int idx);
    case (idx)
      0:       init_delivery = 10'd780;
      1:       init_delivery = 10'd850;
      default: init_delivery = 10'd800;
    endcase
  endfunction

  function automatic logic [LatW-1:0] init_latency(input int idx);
    case (idx)
      0:       init_latency = 16'd900;
      1:       init_latency = 16'd120;
      2:       init_latency = 16'd350;
      default: init_latency = 16'd450;
    endcase
  endfunction

  // all entries sit below 1000
  function automatic logic [9:0] energy_cost(input int idx);
    case (idx)
      0:       energy_cost = 10'd600;
      1:       energy_cost = 10'd420;
      2:       energy_cost = 10'd650;
      default: energy_cost = 10'd560;
    endcase
  endfunction

  function automatic logic [LatW-1:0] div10(input logic [19:0] x);
    logic [43:0] p;
    p = 44'(x) * 44'(DivTenMul);
    div10 = LatW'(p >> DivTenShift);
  endfunction

  // signed score adjustment for link idx under the given mode
  function automatic logic signed [ScoreW-1:0] mode_adjust(input logic [ModeW-1:0] mode,
                                                          input int idx);
    logic signed [ScoreW-1:0] adj;
    adj = '0;
    case (mode)
      ModeRange: begin
        if (idx == 3) adj = BonusRange3;
        else if (idx == 2) adj = BonusRange2;
        else if (idx == 0) adj = BonusRange0;
      end
      ModePowerSave: begin
        adj = -$signed({7'd0, energy_cost(idx), 1'b0});
      end
      ModeBalanced, ModeRedundant: begin
        if (idx == 1) adj = BonusLink1;
      end
      default: adj = '0;
    endcase
    mode_adjust = adj;
  endfunction

endpackage

### src/link_route_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_route_selector: metric keeper and route chooser for radio links
// Top level: stream ports, config registers, input and result registers.
// ----------------------------------------------------------------------------
// The block takes one event item per clock. An accepted item lands in an
// input register; from there it either updates the addressed link's
// record (set up, set live, success, failure, queue depth) or, for a choose
// event, scores all links side by side and loads one result into the output
// register. Only choose events yield a result; every other kind, and any
// event for a link beyond NUM_LINKS, yields none. The rate is one item per
// cycle, set by the combinational score-and-pick path between the two
// registers; it drops only while a finished result waits at the output and
// the next item is a choose. Configuration writes land at once (cfg_ready_o
// is always high) and are meant to be made only while no item is in flight.
// No clearing pass is needed after reset: valid flags, config, records and
// route state reset, and the event and result data flops, which reset does
// not touch, are guarded by their valid flags.
// ----------------------------------------------------------------------------
module link_route_selector #(
  parameter int NUM_LINKS = lrs_pkg::DefaultNumLinks
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lrs_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [lrs_pkg::CfgDataW-1:0]   cfg_data_i,
  // event items
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: link_id[1:0], flag[2], measured_latency[18:3], pending_depth[34:19],
  //        now_time[66:35], zero fill [71:67]
  input  logic [lrs_pkg::InDataW-1:0]    s_axis_tdata_i,
  // tuser: kind[2:0]
  input  logic [lrs_pkg::KindW-1:0]      s_axis_tuser_i,
  // result items
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata: chosen_link[1:0], best_score[19:2] (signed), zero fill [23:20]
  output logic [lrs_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // tuser: none_usable[0]
  output logic                           m_axis_tuser_o
);

  // config registers
  logic [lrs_pkg::ModeW-1:0]   mode_q;
  logic [lrs_pkg::TimeW-1:0]   max_age_q;
  logic [lrs_pkg::TimeW-1:0]   sticky_q;
  logic [lrs_pkg::MarginW-1:0] margin_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= lrs_pkg::RstRouteMode;
      max_age_q <= lrs_pkg::RstMaxAge;
      sticky_q  <= lrs_pkg::RstSticky;
      margin_q  <= lrs_pkg::RstHysteresis;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lrs_pkg::CfgRouteMode:  mode_q    <= cfg_data_i[lrs_pkg::ModeW-1:0];
        lrs_pkg::CfgMaxAge:     max_age_q <= cfg_data_i;
        lrs_pkg::CfgSticky:     sticky_q  <= cfg_data_i;
        lrs_pkg::CfgHysteresis: margin_q  <= cfg_data_i[lrs_pkg::MarginW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  lrs_pkg::event_t ev_d, ev_q;
  logic            in_valid_q;
  logic            is_choose;
  logic            advance;
  logic            in_take;

  always_comb begin
    ev_d.kind    = s_axis_tuser_i;
    ev_d.link_id = s_axis_tdata_i[1:0];
    ev_d.flag    = s_axis_tdata_i[2];
    ev_d.latency = s_axis_tdata_i[18:3];
    ev_d.depth   = s_axis_tdata_i[34:19];
    ev_d.now     = s_axis_tdata_i[66:35];
  end

  assign is_choose = ev_q.kind == lrs_pkg::KindChoose;
  // updates always move on; a choose waits only on a full, stalled output
  assign advance   = in_valid_q && (!is_choose || !m_axis_tvalid_o || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take   = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) ev_q <= ev_d;
  end

  // link records
  lrs_pkg::link_rec_t rec [NUM_LINKS];

  lrs_records #(
    .NUM_LINKS (NUM_LINKS)
  ) u_records (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (advance && !is_choose),
    .ev_i   (ev_q),
    .rec_o  (rec)
  );

  // per-link scoring lanes
  logic                              usable [NUM_LINKS];
  logic signed [lrs_pkg::ScoreW-1:0] score  [NUM_LINKS];

  for (genvar i = 0; i < NUM_LINKS; i++) begin : g_score
    lrs_link_score #(
      .LINK_IDX (i)
    ) u_score (
      .rec_i     (rec[i]),
      .mode_i    (mode_q),
      .max_age_i (max_age_q),
      .now_i     (ev_q.now),
      .usable_o  (usable[i]),
      .score_o   (score[i])
    );
  end

  // best link and previous-route state
  lrs_pkg::result_t res;
  logic             choose_go;

  assign choose_go = advance && is_choose;

  lrs_pick #(
    .NUM_LINKS (NUM_LINKS)
  ) u_pick (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (choose_go),
    .usable_i (usable),
    .score_i  (score),
    .now_i    (ev_q.now),
    .sticky_i (sticky_q),
    .margin_i (margin_q),
    .res_o    (res)
  );

  // result register
  lrs_pkg::result_t res_q;
  logic             out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (choose_go) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (choose_go) res_q <= res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, res_q.score, res_q.chosen};
  assign m_axis_tuser_o  = res_q.none;

endmodule

### src/lrs_records.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_records: per-link metric records
// One record of flops per link, updated in place by the registered event.
// ----------------------------------------------------------------------------
module lrs_records #(
  parameter int NUM_LINKS = lrs_pkg::DefaultNumLinks
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               upd_i,
  input  lrs_pkg::event_t    ev_i,
  output lrs_pkg::link_rec_t rec_o [NUM_LINKS]
);

  for (genvar i = 0; i < NUM_LINKS; i++) begin : g_link
    lrs_pkg::link_rec_t rec_d, rec_q;
    logic               hit;
    logic [19:0]        d_num;
    logic [19:0]        l_num;
    logic [15:0]        d_div;
    logic [15:0]        l_div;
    logic [7:0]         streak_inc;

    assign hit = upd_i && (int'(ev_i.link_id) == i);

    assign d_num = 20'(rec_q.delivery) * 20'd7
                 + ((ev_i.kind == lrs_pkg::KindSuccess) ? lrs_pkg::SuccessAdd : 20'd0);
    assign l_num = 20'(rec_q.latency) * 20'd7 + 20'(ev_i.latency) * 20'd3;
    assign d_div = lrs_pkg::div10(d_num);
    assign l_div = lrs_pkg::div10(l_num);
    assign streak_inc = (rec_q.streak == lrs_pkg::StreakMax) ? rec_q.streak
                                                             : rec_q.streak + 8'd1;

    always_comb begin
      rec_d = rec_q;
      if (hit) begin
        case (ev_i.kind)
          lrs_pkg::KindSetUp: begin
            rec_d.up = ev_i.flag;
            if (!ev_i.flag) begin
              rec_d.live   = 1'b0;
              rec_d.streak = '0;
            end
            rec_d.utime = ev_i.now;
          end
          lrs_pkg::KindSetLive: begin
            rec_d.live = ev_i.flag;
            if (ev_i.flag && rec_q.delivery < lrs_pkg::LiveFloor) begin
              rec_d.delivery = lrs_pkg::LiveFloor;
            end
            rec_d.utime = ev_i.now;
          end
          lrs_pkg::KindSuccess: begin
            rec_d.up       = 1'b1;
            rec_d.live     = 1'b1;
            rec_d.delivery = d_div[lrs_pkg::DeliveryW-1:0];
            rec_d.latency  = l_div;
            rec_d.streak   = '0;
            rec_d.utime    = ev_i.now;
          end
          lrs_pkg::KindFailure: begin
            rec_d.delivery = d_div[lrs_pkg::DeliveryW-1:0];
            rec_d.streak   = streak_inc;
            // the fallback link never drops out on a failure run
            if (streak_inc >= lrs_pkg::StreakDrop && i != 0) rec_d.live = 1'b0;
            rec_d.utime = ev_i.now;
          end
          lrs_pkg::KindQueue: begin
            rec_d.queue = ev_i.depth;
            rec_d.utime = ev_i.now;
          end
          default: rec_d = rec_q;
        endcase
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rec_q.delivery <= lrs_pkg::init_delivery(i);
        rec_q.latency  <= lrs_pkg::init_latency(i);
        rec_q.queue    <= '0;
        rec_q.streak   <= '0;
        rec_q.up       <= 1'b0;
        rec_q.live     <= 1'b0;
        rec_q.utime    <= '0;
      end else begin
        rec_q <= rec_d;
      end
    end

    assign rec_o[i] = rec_q;
  end

endmodule

### src/lrs_link_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_link_score: score of one link
// Usability check (allowed, up, live, fresh) and the weighted score.
// ----------------------------------------------------------------------------
module lrs_link_score #(
  parameter int LINK_IDX = 0
) (
  input  lrs_pkg::link_rec_t                rec_i,
  input  logic [lrs_pkg::ModeW-1:0]         mode_i,
  input  logic [lrs_pkg::TimeW-1:0]         max_age_i,
  input  logic [lrs_pkg::TimeW-1:0]         now_i,
  output logic                              usable_o,
  output logic signed [lrs_pkg::ScoreW-1:0] score_o
);

  logic                              allowed;
  logic                              stale;
  logic [lrs_pkg::TimeW-1:0]         age;
  logic [lrs_pkg::LatW-1:0]          lat_cost;
  logic [10:0]                       queue_cost;
  logic [15:0]                       streak_cost;
  logic signed [lrs_pkg::ScoreW-1:0] base;

  always_comb begin
    allowed = 1'b1;
    if (mode_i >= lrs_pkg::ModeOnlyFirst && mode_i <= lrs_pkg::ModeOnlyLast) begin
      allowed = (int'(mode_i) - 1) == LINK_IDX;
    end
  end

  assign age   = now_i - rec_i.utime;
  // a time stamp of zero means never updated; the fallback link never goes stale
  assign stale = (rec_i.utime != '0) && (age > max_age_i) && (LINK_IDX != 0);

  assign usable_o = allowed && rec_i.up && rec_i.live && !stale;

  assign lat_cost    = (rec_i.latency < lrs_pkg::LatCap) ? rec_i.latency : lrs_pkg::LatCap;
  assign queue_cost  = (rec_i.queue >= lrs_pkg::QueueCapFrom) ? lrs_pkg::QueueCap
                     : 11'(rec_i.queue[3:0]) * 11'(lrs_pkg::QueueWeight);
  assign streak_cost = 16'(rec_i.streak) * 16'(lrs_pkg::StreakWeight);

  assign base = $signed(18'(rec_i.delivery) * 18'd6)
              - $signed(18'(lat_cost))
              - $signed(18'(queue_cost))
              - $signed(18'(lrs_pkg::energy_cost(LINK_IDX)))
              - $signed(18'(streak_cost));

  assign score_o = base + lrs_pkg::mode_adjust(mode_i, LINK_IDX);

endmodule

### src/lrs_pick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_pick: best link and sticky previous route
// Picks the best usable link, favors the previous route inside the sticky
// window, and keeps the previous-route state.
// ----------------------------------------------------------------------------
module lrs_pick #(
  parameter int NUM_LINKS = lrs_pkg::DefaultNumLinks
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              commit_i,
  input  logic                              usable_i [NUM_LINKS],
  input  logic signed [lrs_pkg::ScoreW-1:0] score_i  [NUM_LINKS],
  input  logic [lrs_pkg::TimeW-1:0]         now_i,
  input  logic [lrs_pkg::TimeW-1:0]         sticky_i,
  input  logic [lrs_pkg::MarginW-1:0]       margin_i,
  output lrs_pkg::result_t                  res_o
);

  localparam int IdxW = $clog2(NUM_LINKS);

  logic [IdxW-1:0]                   prev_link_q;
  logic [lrs_pkg::TimeW-1:0]         prev_time_q;
  logic                              have_prev_q;

  logic [IdxW-1:0]                   top_link;
  logic signed [lrs_pkg::ScoreW-1:0] top_score;
  logic                              top_valid;
  logic                              prev_ok;
  logic signed [lrs_pkg::ScoreW:0]   prev_bar;
  logic                              keep_prev;
  logic [IdxW-1:0]                   best;
  logic signed [lrs_pkg::ScoreW-1:0] best_score;
  logic                              valid;

  // first strictly greater score wins, so a tie keeps the lower link
  always_comb begin
    top_valid = 1'b0;
    top_link  = '0;
    top_score = '0;
    for (int i = 0; i < NUM_LINKS; i++) begin
      if (usable_i[i] && (!top_valid || score_i[i] > top_score)) begin
        top_valid = 1'b1;
        top_score = score_i[i];
        top_link  = IdxW'(i);
      end
    end
  end

  assign prev_ok  = have_prev_q && ((now_i - prev_time_q) < sticky_i) && usable_i[prev_link_q];
  // both sides of the margin compare are signed, one bit wider than a score
  assign prev_bar = $signed({score_i[prev_link_q][lrs_pkg::ScoreW-1], score_i[prev_link_q]})
                  + $signed({3'b000, margin_i});
  assign keep_prev = prev_ok &&
                     (!top_valid ||
                      ($signed({top_score[lrs_pkg::ScoreW-1], top_score}) < prev_bar));

  assign best       = keep_prev ? prev_link_q : top_link;
  assign best_score = keep_prev ? score_i[prev_link_q] : top_score;
  assign valid      = top_valid || keep_prev;

  always_comb begin
    res_o.chosen = valid ? lrs_pkg::LinkIdW'(best) : '0;
    res_o.score  = valid ? best_score : '0;
    res_o.none   = !valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_link_q <= '0;
      prev_time_q <= '0;
      have_prev_q <= 1'b0;
    end else if (commit_i) begin
      prev_link_q <= valid ? best : '0;
      prev_time_q <= now_i;
      have_prev_q <= valid;
    end
  end

endmodule
